// File: design/pip_pkg.sv
// shared types, constants and microcode rom for the point-in-polygon test
// used by pip_seq and point_in_polygon_test; no other dependencies
package pip_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = 5;
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int STEP_W       = 3;

	// configuration register index, taken from paddr[2]
	localparam logic REG_VCOUNT = 1'b0;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// microcode steps
	localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_RD_LAST = 3'd1;
	localparam logic [STEP_W-1:0] STEP_RD_LOOP = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DRAIN   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DONE    = 3'd4;

	// jump conditions
	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_NO_TEST = 3'd2;
	localparam logic [2:0] C_N_ZERO  = 3'd3;
	localparam logic [2:0] C_MORE    = 3'd4;
	localparam logic [2:0] C_BUSY    = 3'd5;

	typedef struct packed {
		logic              idle;
		logic              rd_last;
		logic              rd_idx;
		logic              done;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic             test_acc;
		logic             n_zero;
		logic             pipe_busy;
		logic [IDX_W-1:0] last_idx;
	} seq_stat_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic             idle;
		logic             rd_en;
		logic             edge_rd;
		logic             done;
		logic [IDX_W-1:0] rd_addr;
	} seq_ctl_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{idle: 1'b0, rd_last: 1'b0, rd_idx: 1'b0, done: 1'b0,
			cond: C_ALWAYS, target: STEP_IDLE};
		case (step)
			STEP_IDLE: begin
				w.idle   = 1'b1;
				w.cond   = C_NO_TEST;
				w.target = STEP_IDLE;
			end
			STEP_RD_LAST: begin
				// closing vertex first, it is the previous end of edge 0
				w.rd_last = 1'b1;
				w.cond    = C_N_ZERO;
				w.target  = STEP_DRAIN;
			end
			STEP_RD_LOOP: begin
				w.rd_idx = 1'b1;
				w.cond   = C_MORE;
				w.target = STEP_RD_LOOP;
			end
			STEP_DRAIN: begin
				w.cond   = C_BUSY;
				w.target = STEP_DRAIN;
			end
			STEP_DONE: begin
				w.done   = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: design/pip_seq.sv
// microcode sequencer: step counter, control rom, vertex index counter
// depends on pip_pkg
module pip_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_pkg::seq_stat_t  stat,
	output pip_pkg::seq_ctl_t   ctl
);

	logic [pip_pkg::STEP_W-1:0] step_q;
	logic [pip_pkg::STEP_W-1:0] step_d;
	logic [pip_pkg::IDX_W-1:0]  idx_q;
	pip_pkg::ucode_t            word;
	logic                       take;

	assign word = pip_pkg::ucode_rom(step_q);

	always_comb begin
		case (word.cond)
			pip_pkg::C_NEVER:   take = 1'b0;
			pip_pkg::C_ALWAYS:  take = 1'b1;
			pip_pkg::C_NO_TEST: take = !stat.test_acc;
			pip_pkg::C_N_ZERO:  take = stat.n_zero;
			pip_pkg::C_MORE:    take = (idx_q != stat.last_idx);
			pip_pkg::C_BUSY:    take = stat.pipe_busy;
			default:            take = 1'b1;
		endcase
		step_d = take ? word.target : step_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pip_pkg::STEP_IDLE;
			idx_q  <= '0;
		end else begin
			step_q <= step_d;
			if (word.rd_last) begin
				idx_q <= '0;
			end else if (word.rd_idx) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign ctl.idle    = word.idle;
	assign ctl.rd_en   = word.rd_last | word.rd_idx;
	assign ctl.edge_rd = word.rd_idx;
	assign ctl.done    = word.done;
	assign ctl.rd_addr = word.rd_last ? stat.last_idx : idx_q;

	// a test leaves idle for the closing-vertex read
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == pip_pkg::STEP_IDLE && stat.test_acc) |=> step_q == pip_pkg::STEP_RD_LAST)
		else $error("test accepted but sequencer did not start");

	// result only once every edge has left the pipeline
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		word.done |-> !stat.pipe_busy)
		else $error("result given with edges in flight");

	// result is followed by idle
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		word.done |=> step_q == pip_pkg::STEP_IDLE)
		else $error("sequencer did not return to idle");

	// no store read while idle, so loads never collide with reads
	a_no_rd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.idle |-> !ctl.rd_en)
		else $error("store read while idle");

endmodule

// File: design/point_in_polygon_test.sv
// crossing-number point-in-polygon test, top level: apb register, vertex store, edge datapath
// depends on pip_pkg and pip_seq
//
// usage: a word is accepted when start is high and busy is low. cmd selects a load
// (coord_x/coord_y written to store slot vertex_index, no result, busy stays low so
// another word can follow in the next cycle) or a test (coord_x/coord_y is the point).
// a test raises busy and runs the first vertex_count vertices (saturated to 16) through
// a four-stage edge pipeline: store read, differences, two 17x17 products, compare and
// parity toggle. the microcode issues one store read per cycle: the closing vertex,
// then vertices 0 to n-1, then waits for the pipeline to drain.
// a count of zero skips the vertex loop. busy falls in the cycle after done, and a new
// test is accepted only while busy is low, so tests do not overlap.
// the store read port, one vertex per cycle, sets the rate.
// done is high for exactly one cycle with inside_res; the receiver cannot stall it.
// vertex_count is written over apb when paddr[2] is 0; write it only while busy is low,
// the block does not enforce this.
// reset clears the sequencer, pipeline valids and sets vertex_count to 3; the store is
// not cleared, so every slot in use must be loaded before a test.
module point_in_polygon_test (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [3:0]  vertex_index,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	// result channel
	output logic        done,
	output logic        inside_res,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = pip_pkg::COORD_W;
	localparam int DW = pip_pkg::DIFF_W;
	localparam int PW = pip_pkg::PROD_W;

	pip_pkg::seq_stat_t stat;
	pip_pkg::seq_ctl_t  ctl;

	logic [pip_pkg::CNT_W-1:0] vcount_q;
	logic [pip_pkg::CNT_W-1:0] n_eff;
	logic [pip_pkg::CNT_W-1:0] n_last;
	logic                      acc;
	logic                      load_acc;
	logic                      test_acc;

	logic [2*CW-1:0] mem_q [pip_pkg::MAX_VERTICES];
	logic [2*CW-1:0] rd_s1;
	logic            vld_s1;
	logic            edge_s1;

	logic signed [CW-1:0] px_q, py_q;
	logic signed [CW-1:0] xp_q, yp_q;
	logic signed [CW-1:0] xc, yc;

	logic signed [DW-1:0] dy_s2, a_s2, b_s2, c_s2;
	logic                 crs_s2, vld_s2;

	logic signed [PW-1:0] lhs_s3, rhs_s3;
	logic                 dypos_s3, crs_s3, vld_s3;
	logic                 left;
	logic                 parity_q;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= pip_pkg::CNT_W'(3);
		end else if (psel && penable && pwrite && pready && paddr[2] == pip_pkg::REG_VCOUNT) begin
			vcount_q <= pwdata[pip_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pip_pkg::REG_VCOUNT) begin
			prdata[pip_pkg::CNT_W-1:0] = vcount_q;
		end
	end

	assign n_eff  = (vcount_q > pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES))
		? pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES) : vcount_q;
	assign n_last = n_eff - 1'b1;

	// command handshake
	assign busy     = !ctl.idle;
	assign acc      = start && !busy;
	assign load_acc = acc && cmd == pip_pkg::CMD_LOAD;
	assign test_acc = acc && cmd == pip_pkg::CMD_TEST;

	assign stat.test_acc  = test_acc;
	assign stat.n_zero    = (n_eff == '0);
	assign stat.pipe_busy = vld_s1 | vld_s2 | vld_s3;
	assign stat.last_idx  = n_last[pip_pkg::IDX_W-1:0];

	pip_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// vertex store: y in the upper half, x in the lower half
	always_ff @(posedge clk) begin
		if (load_acc) begin
			mem_q[vertex_index] <= {coord_y, coord_x};
		end
		if (ctl.rd_en) begin
			rd_s1 <= mem_q[ctl.rd_addr];
		end
		if (test_acc) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
	end

	assign xc = rd_s1[CW-1:0];
	assign yc = rd_s1[2*CW-1:CW];

	// stage 2: previous vertex register and differences
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			xp_q <= xc;
			yp_q <= yc;
		end
		if (vld_s1 && edge_s1) begin
			dy_s2  <= {yp_q[CW-1], yp_q} - {yc[CW-1], yc};
			a_s2   <= {px_q[CW-1], px_q} - {xc[CW-1], xc};
			b_s2   <= {xp_q[CW-1], xp_q} - {xc[CW-1], xc};
			c_s2   <= {py_q[CW-1], py_q} - {yc[CW-1], yc};
			crs_s2 <= (yc > py_q) != (yp_q > py_q);
		end
	end

	// stage 3: cross products
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			lhs_s3   <= a_s2 * dy_s2;
			rhs_s3   <= b_s2 * c_s2;
			dypos_s3 <= !dy_s2[DW-1] && dy_s2 != '0;
			crs_s3   <= crs_s2;
		end
	end

	// point left of the crossing; compare direction follows the sign of the y span
	assign left = dypos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			edge_s1  <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			vld_s1  <= ctl.rd_en;
			edge_s1 <= ctl.edge_rd;
			vld_s2  <= vld_s1 && edge_s1;
			vld_s3  <= vld_s2;
			if (test_acc) begin
				parity_q <= 1'b0;
			end else if (vld_s3 && crs_s3 && left) begin
				parity_q <= !parity_q;
			end
		end
	end

	assign done       = ctl.done;
	assign inside_res = parity_q;

endmodule
